>>> sv/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg: shared types and constants for barometric compensation
// Transfer structs, register index codes and the pipeline latency.
// ----------------------------------------------------------------------------
`default_nettype none

package btpc_pkg;

	localparam int unsigned RAW_W     = 20;
	localparam int unsigned CFG_W     = 64;
	localparam int unsigned DIV_STEPS = 64;
	// front stages, divider steps, back stages and output register
	localparam int unsigned LATENCY   = 10 + DIV_STEPS + 6;

	typedef enum logic [1:0] {
		REG_TEMP_CAL   = 2'd0,
		REG_PRESS_LOW  = 2'd1,
		REG_PRESS_HIGH = 2'd2,
		REG_PRESS_P9   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_temperature;
		logic [RAW_W-1:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic               divide_fault;
	} result_t;

endpackage

`default_nettype wire

>>> sv/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation: barometric sensor compensation pipeline
// Raw 20-bit temperature and pressure in, 0.01 degC and Q24.8 pascals out.
// ----------------------------------------------------------------------------
// Usage
//   Calibration: write cfg_wdata to register cfg_index while cfg_we is high.
//   Registers: 0 T1/T2/T3, 1 P1..P4, 2 P5..P8, 3 P9. Write only while idle.
//   Input: a sample transfers at a rising edge with start high and busy low.
//   busy is held low: one sample may transfer in every cycle.
//   Output: done strobes for one cycle with the result on result; the
//   receiver cannot stall, so no back pressure exists anywhere.
//   Stages: a transfer passes 10 front stages, 64 divider steps and 6 back
//   stages incl. output before done strobes.
//   Throughput: one sample per cycle; the 64 single-bit restoring divider
//   steps, each a 32-bit compare and subtract, set the stage count, and the
//   64x16 products set the clock.
//   A zero divisor forces pressure to 0 and raises divide_fault; the
//   temperature is still reported.
//   Reset: clears all stage valid bits and calibration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_temp_pressure_compensation (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire btpc_pkg::sample_t  sample,
	output logic                    done,
	output btpc_pkg::result_t       result,
	input  wire logic               cfg_we,
	input  wire btpc_pkg::cfg_idx_t cfg_index,
	input  wire logic [63:0]        cfg_wdata
);
	import btpc_pkg::*;

	// calibration registers
	logic [47:0] temp_cal_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [15:0] press_p9_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q   <= '0;
			press_low_q  <= '0;
			press_high_q <= '0;
			press_p9_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP_CAL:   temp_cal_q   <= cfg_wdata[47:0];
				REG_PRESS_LOW:  press_low_q  <= cfg_wdata;
				REG_PRESS_HIGH: press_high_q <= cfg_wdata;
				REG_PRESS_P9:   press_p9_q   <= cfg_wdata[15:0];
				default:        ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = temp_cal_q[15:0];
	assign t2 = $signed(temp_cal_q[31:16]);
	assign t3 = $signed(temp_cal_q[47:32]);
	assign p1 = press_low_q[15:0];
	assign p2 = $signed(press_low_q[31:16]);
	assign p3 = $signed(press_low_q[47:32]);
	assign p4 = $signed(press_low_q[63:48]);
	assign p5 = $signed(press_high_q[15:0]);
	assign p6 = $signed(press_high_q[31:16]);
	assign p7 = $signed(press_high_q[47:32]);
	assign p8 = $signed(press_high_q[63:48]);
	assign p9 = $signed(press_p9_q);

	// the pipeline never holds off a sample
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---- stage 1: linear temperature term and squared offset
	logic               vld_s1;
	logic signed [33:0] tmul_s1;
	logic [31:0]        dd_s1;
	logic [19:0]        adcp_s1;
	logic signed [17:0] ta;
	logic signed [16:0] td;
	logic signed [33:0] tdd;

	always_comb begin
		ta  = $signed({1'b0, sample.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
		td  = $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, t1});
		tdd = td * td;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		tmul_s1 <= ta * t2;
		dd_s1   <= tdd[31:0];
		adcp_s1 <= sample.raw_pressure;
	end

	// ---- stage 2: scale linear term, multiply square by T3
	logic               vld_s2;
	logic signed [22:0] v1t_s2;
	logic signed [36:0] v2pre_s2;
	logic [19:0]        adcp_s2;
	logic signed [33:0] tmul_sh;

	assign tmul_sh = tmul_s1 >>> 11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		v1t_s2   <= tmul_sh[22:0];
		v2pre_s2 <= $signed({1'b0, dd_s1[31:12]}) * t3;
		adcp_s2  <= adcp_s1;
	end

	// ---- stage 3: fine temperature
	logic               vld_s3;
	logic signed [25:0] tfine_s3;
	logic [19:0]        adcp_s3;
	logic signed [36:0] v2_sh;

	assign v2_sh = v2pre_s2 >>> 14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		tfine_s3 <= 26'(v1t_s2) + v2_sh[25:0];
		adcp_s3  <= adcp_s2;
	end

	// ---- stage 4: centidegree result with saturation, pressure offset
	logic               vld_s4;
	logic signed [15:0] temp_s4;
	logic signed [26:0] pv1_s4;
	logic [19:0]        adcp_s4;
	logic signed [28:0] t5;
	logic signed [28:0] tc;
	logic signed [15:0] tsat;

	always_comb begin
		t5 = 29'(tfine_s3) * 29'sd5 + 29'sd128;
		tc = t5 >>> 8;
		if (tc > 29'sd32767)       tsat = 16'sh7fff;
		else if (tc < -29'sd32768) tsat = 16'sh8000;
		else                       tsat = tc[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		temp_s4 <= tsat;
		pv1_s4  <= 27'(tfine_s3) - 27'sd128000;
		adcp_s4 <= adcp_s3;
	end

	// ---- stage 5: square and linear products of the offset
	logic               vld_s5;
	logic signed [53:0] sq_s5;
	logic signed [42:0] m5_s5, m2_s5;
	logic signed [15:0] temp_s5;
	logic [19:0]        adcp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		sq_s5   <= pv1_s4 * pv1_s4;
		m5_s5   <= pv1_s4 * p5;
		m2_s5   <= pv1_s4 * p2;
		temp_s5 <= temp_s4;
		adcp_s5 <= adcp_s4;
	end

	// ---- stage 6: square times P6 and P3, wrapped to 64 bits
	logic               vld_s6;
	logic [63:0]        a6_s6, a3_s6;
	logic signed [42:0] m5_s6, m2_s6;
	logic signed [15:0] temp_s6;
	logic [19:0]        adcp_s6;
	logic signed [69:0] a6w, a3w;

	always_comb begin
		a6w = sq_s5 * p6;
		a3w = sq_s5 * p3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		a6_s6   <= a6w[63:0];
		a3_s6   <= a3w[63:0];
		m5_s6   <= m5_s5;
		m2_s6   <= m2_s5;
		temp_s6 <= temp_s5;
		adcp_s6 <= adcp_s5;
	end

	// ---- stage 7: sum the divisor and numerator offset terms
	logic               vld_s7;
	logic [63:0]        v2_s7, v1c_s7;
	logic signed [15:0] temp_s7;
	logic [19:0]        adcp_s7;
	logic [63:0]        m5x, m2x, p4x, a3sh;

	always_comb begin
		m5x  = {{21{m5_s6[42]}}, m5_s6};
		m2x  = {{21{m2_s6[42]}}, m2_s6};
		p4x  = {{48{p4[15]}}, p4};
		a3sh = $signed(a3_s6) >>> 8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else         vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		v2_s7   <= a6_s6 + (m5x << 17) + (p4x << 35);
		v1c_s7  <= a3sh + (m2x << 12) + (64'd1 << 47);
		temp_s7 <= temp_s6;
		adcp_s7 <= adcp_s6;
	end

	// ---- stage 8: scale by P1, form numerator before the 3125 factor
	logic               vld_s8;
	logic [63:0]        prod_s8, num_s8;
	logic signed [15:0] temp_s8;
	logic [79:0]        p1w;
	logic [20:0]        np;

	always_comb begin
		p1w = v1c_s7 * p1;
		np  = 21'h100000 - {1'b0, adcp_s7};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else         vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		prod_s8 <= p1w[63:0];
		num_s8  <= {12'd0, np, 31'd0} - v2_s7;
		temp_s8 <= temp_s7;
	end

	// ---- stage 9: divisor and scaled numerator
	logic               vld_s9;
	logic [63:0]        numer_s9;
	logic signed [30:0] div_s9;
	logic signed [15:0] temp_s9;
	logic [75:0]        nw;

	assign nw = num_s8 * 12'd3125;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else         vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		numer_s9 <= nw[63:0];
		div_s9   <= $signed(prod_s8[63:33]);
		temp_s9  <= temp_s8;
	end

	// ---- stage 10: magnitudes and quotient sign
	logic               vld_s10;
	logic [63:0]        na_s10;
	logic [30:0]        db_s10;
	logic               neg_s10, fault_s10;
	logic signed [15:0] temp_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s10 <= 1'b0;
		else         vld_s10 <= vld_s9;
	end

	always_ff @(posedge clk) begin
		na_s10    <= numer_s9[63] ? (64'd0 - numer_s9) : numer_s9;
		db_s10    <= div_s9[30] ? (31'd0 - div_s9) : div_s9;
		neg_s10   <= numer_s9[63] ^ div_s9[30];
		fault_s10 <= (div_s9 == 31'sd0);
		temp_s10  <= temp_s9;
	end

	// ---- divider: one restoring step per stage, quotient shifts into word
	logic               dv_vld_sdiv   [DIV_STEPS];
	logic [63:0]        dv_word_sdiv  [DIV_STEPS];
	logic [31:0]        dv_rem_sdiv   [DIV_STEPS];
	logic [30:0]        dv_den_sdiv   [DIV_STEPS];
	logic               dv_neg_sdiv   [DIV_STEPS];
	logic               dv_fault_sdiv [DIV_STEPS];
	logic signed [15:0] dv_temp_sdiv  [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic               vin, nin, fin;
		logic [63:0]        win;
		logic [31:0]        rin;
		logic [30:0]        din;
		logic signed [15:0] tin;
		logic [31:0]        trial;
		logic               take;

		if (k == 0) begin : g_first
			assign vin = vld_s10;
			assign win = na_s10;
			assign rin = '0;
			assign din = db_s10;
			assign nin = neg_s10;
			assign fin = fault_s10;
			assign tin = temp_s10;
		end else begin : g_next
			assign vin = dv_vld_sdiv[k-1];
			assign win = dv_word_sdiv[k-1];
			assign rin = dv_rem_sdiv[k-1];
			assign din = dv_den_sdiv[k-1];
			assign nin = dv_neg_sdiv[k-1];
			assign fin = dv_fault_sdiv[k-1];
			assign tin = dv_temp_sdiv[k-1];
		end

		assign trial = {rin[30:0], win[63]};
		assign take  = (trial >= {1'b0, din});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_sdiv[k] <= 1'b0;
			else         dv_vld_sdiv[k] <= vin;
		end

		always_ff @(posedge clk) begin
			dv_rem_sdiv[k]   <= take ? (trial - {1'b0, din}) : trial;
			dv_word_sdiv[k]  <= {win[62:0], take};
			dv_den_sdiv[k]   <= din;
			dv_neg_sdiv[k]   <= nin;
			dv_fault_sdiv[k] <= fin;
			dv_temp_sdiv[k]  <= tin;
		end
	end

	localparam int unsigned LAST = DIV_STEPS - 1;

	// ---- stage 11: signed quotient, zero on fault
	logic               vld_s11, fault_s11;
	logic [63:0]        q_s11;
	logic signed [15:0] temp_s11;
	logic [63:0]        qw;

	assign qw = dv_word_sdiv[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s11 <= 1'b0;
		else         vld_s11 <= dv_vld_sdiv[LAST];
	end

	always_ff @(posedge clk) begin
		if (dv_fault_sdiv[LAST])    q_s11 <= '0;
		else if (dv_neg_sdiv[LAST]) q_s11 <= 64'd0 - qw;
		else                        q_s11 <= qw;
		fault_s11 <= dv_fault_sdiv[LAST];
		temp_s11  <= dv_temp_sdiv[LAST];
	end

	// ---- stage 12: P9 and P8 products
	logic               vld_s12, fault_s12;
	logic [63:0]        q_s12, s_s12, m1_s12, m8_s12;
	logic signed [15:0] temp_s12;
	logic [63:0]        qs;
	logic signed [79:0] m1w, m8w;

	always_comb begin
		qs  = $signed(q_s11) >>> 13;
		m1w = p9 * $signed(qs);
		m8w = p8 * $signed(q_s11);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s12 <= 1'b0;
		else         vld_s12 <= vld_s11;
	end

	always_ff @(posedge clk) begin
		q_s12     <= q_s11;
		s_s12     <= qs;
		m1_s12    <= m1w[63:0];
		m8_s12    <= m8w[63:0];
		fault_s12 <= fault_s11;
		temp_s12  <= temp_s11;
	end

	// ---- stage 13: 32-bit partial products of the low 64-bit square term
	logic               vld_s13, fault_s13;
	logic [63:0]        q_s13, m8_s13, pp0_s13;
	logic [31:0]        pp1_s13, pp2_s13;
	logic signed [15:0] temp_s13;
	logic [63:0]        pp1w, pp2w;

	always_comb begin
		pp1w = m1_s12[31:0] * s_s12[63:32];
		pp2w = m1_s12[63:32] * s_s12[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s13 <= 1'b0;
		else         vld_s13 <= vld_s12;
	end

	always_ff @(posedge clk) begin
		pp0_s13   <= m1_s12[31:0] * s_s12[31:0];
		pp1_s13   <= pp1w[31:0];
		pp2_s13   <= pp2w[31:0];
		q_s13     <= q_s12;
		m8_s13    <= m8_s12;
		fault_s13 <= fault_s12;
		temp_s13  <= temp_s12;
	end

	// ---- stage 14: combine partial products
	logic               vld_s14, fault_s14;
	logic [63:0]        q_s14, m8_s14, sq9_s14;
	logic signed [15:0] temp_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s14 <= 1'b0;
		else         vld_s14 <= vld_s13;
	end

	always_ff @(posedge clk) begin
		sq9_s14   <= pp0_s13 + {pp1_s13 + pp2_s13, 32'd0};
		q_s14     <= q_s13;
		m8_s14    <= m8_s13;
		fault_s14 <= fault_s13;
		temp_s14  <= temp_s13;
	end

	// ---- stage 15: sum quotient and correction terms
	logic               vld_s15, fault_s15;
	logic [63:0]        tot_s15;
	logic signed [15:0] temp_s15;
	logic [63:0]        v1q, v2q;

	always_comb begin
		v1q = $signed(sq9_s14) >>> 25;
		v2q = $signed(m8_s14) >>> 19;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s15 <= 1'b0;
		else         vld_s15 <= vld_s14;
	end

	always_ff @(posedge clk) begin
		tot_s15   <= q_s14 + v1q + v2q;
		fault_s15 <= fault_s14;
		temp_s15  <= temp_s14;
	end

	// ---- output register: Q24.8 offset by P7, drop pressure on fault
	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= vld_s15;
	end

	always_ff @(posedge clk) begin
		result_q.temperature_centi <= temp_s15;
		result_q.pressure_q24_8    <= fault_s15 ? 32'd0 :
			tot_s15[39:8] + {{12{p7[15]}}, p7, 4'd0};
		result_q.divide_fault      <= fault_s15;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> sv/btpc_checker.sv
// ----------------------------------------------------------------------------
// btpc_checker: port-level checks for the compensation pipeline
// Latency, no back pressure and fault reporting seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire btpc_pkg::result_t result
);
	import btpc_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done) else $error("transfer lost");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done) else $error("spurious result");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.divide_fault) |-> (result.pressure_q24_8 == 32'd0))
		else $error("fault with pressure");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
